// ===== hdl/rms_error_accumulator_assert.svh =====
// Assertion macros shared by the rms error accumulator RTL.
`ifndef RMS_ERROR_ACCUMULATOR_ASSERT_SVH
`define RMS_ERROR_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define REA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rea assertion failed");

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define REA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rea assertion failed");

`endif

// ===== hdl/rea_pkg.sv =====
// Package: widths, constants and controller/datapath interface types.
`timescale 1ns / 1ps
`default_nettype none
package rea_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int SQ_W       = 32;
    localparam int SUM_W      = 53;
    localparam int CNT_W      = 21;
    localparam int MEAN_W     = 32;
    localparam int ROOT_W     = 16;
    localparam int DIV_STEPS  = SUM_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);
    localparam int SREM_W     = ROOT_W + 2;

    localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(1048576);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic take;       // accumulate the beat on the input port
        logic div_load;   // snapshot sum/count into divider, clear accumulator
        logic div_step;   // one quotient bit
        logic sqrt_load;  // start root on the quotient
        logic sqrt_step;  // one root bit
        logic out_load;   // move result into the output register
    } rea_cmd_t;

    // Status back to the controller
    typedef struct packed {
        logic out_free;   // output register can take a result this cycle
    } rea_stat_t;

endpackage
`default_nettype wire

// ===== hdl/rea_ctrl.sv =====
// Controller: sequences accumulate, divide, square root and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
`include "rms_error_accumulator_assert.svh"
module rea_ctrl
    import rea_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    input  wire logic      s_last,
    output logic           s_ready,
    output rea_cmd_t       cmd,
    input  wire rea_stat_t stat
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_FLUSH = 7'b0000010,
        ST_LOAD  = 7'b0000100,
        ST_DIV   = 7'b0001000,
        ST_SQLD  = 7'b0010000,
        ST_SQRT  = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              take;

    assign s_ready = (state_reg == ST_IDLE);
    assign take    = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                cmd.take = take;
                if (take && s_last) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                // last square lands in the sum this cycle
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                cmd.div_load = 1'b1;
                step_next    = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    state_next = ST_SQLD;
                end
            end
            ST_SQLD: begin
                cmd.sqrt_load = 1'b1;
                step_next     = '0;
                state_next    = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                step_next     = step_reg + 1'b1;
                if (step_reg == STEP_W'(SQRT_STEPS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    `REA_ASSERT_NEXT(a_last_blocks_input, take && s_last, !s_ready)
    `REA_ASSERT_NOW(a_div_step_in_range, state_reg == ST_DIV,
                    step_reg <= STEP_W'(DIV_STEPS - 1))
    `REA_ASSERT_NOW(a_state_onehot, 1'b1, $onehot(state_reg))

endmodule
`default_nettype wire

// ===== hdl/rea_datapath.sv =====
// Datapath: squared-difference accumulator, serial divider, serial root, output register.
`timescale 1ns / 1ps
`default_nettype none
`include "rms_error_accumulator_assert.svh"
module rea_datapath
    import rea_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire rea_cmd_t                   cmd,
    output rea_stat_t                       stat,
    input  wire logic signed [SAMPLE_W-1:0] s_sample_a,
    input  wire logic                       s_a_finite,
    input  wire logic signed [SAMPLE_W-1:0] s_sample_b,
    input  wire logic                       s_b_finite,
    output logic             [MEAN_W-1:0]   m_mean_square,
    output logic             [ROOT_W-1:0]   m_rms,
    output logic             [CNT_W-1:0]    m_valid_count,
    output logic                            m_mismatch,
    output logic                            m_overflow,
    output logic                            m_valid,
    input  wire logic                       m_ready
);

    // accumulator
    logic [SUM_W-1:0]  sum_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              mis_reg;
    logic              ovf_reg;
    logic              pend_reg;
    logic [SQ_W-1:0]   sq_reg;

    // divider
    logic [SUM_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  drem_reg;
    logic [CNT_W-1:0]  divisor_reg;
    logic              res_mis_reg;
    logic              res_ovf_reg;

    // root
    logic [MEAN_W-1:0] mean_reg;
    logic [MEAN_W-1:0] sq_op_reg;
    logic [SREM_W-1:0] srem_reg;
    logic [ROOT_W-1:0] root_reg;

    // output register
    logic              m_valid_reg;
    logic [MEAN_W-1:0] m_mean_reg;
    logic [ROOT_W-1:0] m_rms_reg;
    logic [CNT_W-1:0]  m_cnt_reg;
    logic              m_mis_reg;
    logic              m_ovf_reg;

    logic signed [SAMPLE_W:0] diff;
    logic        [SAMPLE_W:0] mag;
    logic        [SQ_W-1:0]   sq_next;
    logic                     both_fin;
    logic                     room;
    logic        [CNT_W:0]    div_sh;
    logic        [CNT_W:0]    div_diff;
    logic                     div_ge;
    logic        [SREM_W+1:0] sq_sh;
    logic        [SREM_W+1:0] sq_trial;
    logic                     sq_ge;

    assign diff     = {s_sample_a[SAMPLE_W-1], s_sample_a}
                    - {s_sample_b[SAMPLE_W-1], s_sample_b};
    assign mag      = diff[SAMPLE_W] ? (SAMPLE_W+1)'(-diff) : diff;
    assign sq_next  = mag[SAMPLE_W-1:0] * mag[SAMPLE_W-1:0];
    assign both_fin = s_a_finite && s_b_finite;
    assign room     = (count_reg < MAX_COUNT);

    assign div_sh   = {drem_reg, quo_reg[SUM_W-1]};
    assign div_diff = div_sh - {1'b0, divisor_reg};
    assign div_ge   = (div_sh >= {1'b0, divisor_reg});

    assign sq_sh    = {srem_reg, sq_op_reg[MEAN_W-1 -: 2]};
    assign sq_trial = {2'b00, root_reg, 2'b01};
    assign sq_ge    = (sq_sh >= sq_trial);

    assign stat.out_free = !m_valid_reg || m_ready;

    // accumulator: square is registered, added to the sum in the next cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            count_reg <= '0;
            mis_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
            pend_reg  <= 1'b0;
        end else if (cmd.div_load) begin
            sum_reg   <= '0;
            count_reg <= '0;
            mis_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
            pend_reg  <= 1'b0;
        end else begin
            pend_reg <= cmd.take && both_fin && room;
            if (pend_reg) begin
                sum_reg <= sum_reg + {{(SUM_W-SQ_W){1'b0}}, sq_reg};
            end
            if (cmd.take) begin
                if (s_a_finite != s_b_finite) begin
                    mis_reg <= 1'b1;
                end
                if (both_fin) begin
                    if (room) begin
                        count_reg <= count_reg + 1'b1;
                    end else begin
                        ovf_reg <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            sq_reg <= sq_next;
        end
    end

    // restoring divider, one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (cmd.div_load) begin
            quo_reg     <= sum_reg;
            drem_reg    <= '0;
            divisor_reg <= count_reg;
            res_mis_reg <= mis_reg;
            res_ovf_reg <= ovf_reg;
        end else if (cmd.div_step) begin
            quo_reg  <= {quo_reg[SUM_W-2:0], div_ge};
            drem_reg <= div_ge ? div_diff[CNT_W-1:0] : div_sh[CNT_W-1:0];
        end
    end

    // digit-by-digit root, one bit per cycle
    always_ff @(posedge aclk) begin
        if (cmd.sqrt_load) begin
            mean_reg  <= (divisor_reg == '0) ? '0 : quo_reg[MEAN_W-1:0];
            sq_op_reg <= (divisor_reg == '0) ? '0 : quo_reg[MEAN_W-1:0];
            srem_reg  <= '0;
            root_reg  <= '0;
        end else if (cmd.sqrt_step) begin
            sq_op_reg <= {sq_op_reg[MEAN_W-3:0], 2'b00};
            srem_reg  <= sq_ge ? SREM_W'(sq_sh - sq_trial) : SREM_W'(sq_sh);
            root_reg  <= {root_reg[ROOT_W-2:0], sq_ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_mean_reg <= mean_reg;
            m_rms_reg  <= root_reg;
            m_cnt_reg  <= divisor_reg;
            m_mis_reg  <= res_mis_reg;
            m_ovf_reg  <= res_ovf_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_mean_square = m_mean_reg;
    assign m_rms         = m_rms_reg;
    assign m_valid_count = m_cnt_reg;
    assign m_mismatch    = m_mis_reg;
    assign m_overflow    = m_ovf_reg;

    `REA_ASSERT_NOW(a_no_overwrite, cmd.out_load, !m_valid_reg || m_ready)
    `REA_ASSERT_NEXT(a_acc_cleared, cmd.div_load,
                     sum_reg == '0 && count_reg == '0 && !mis_reg && !ovf_reg)
    `REA_ASSERT_NOW(a_root_floor, cmd.out_load,
                    ({16'b0, root_reg} * {16'b0, root_reg}) <= mean_reg)

endmodule
`default_nettype wire

// ===== hdl/rms_error_accumulator.sv =====
// A beat without last is taken as it is offered; s_ready stays high for back-to-back beats.
// A beat with last starts its result: the sum settles, the one-bit-per-cycle divider runs,
// the one-bit-per-cycle root is loaded and run, and the result moves to the output register.
// s_ready is low until the output register takes it; then beats flow at one per cycle again.
// Reset (aresetn low at a clock edge) empties the accumulator and drops m_valid.
`timescale 1ns / 1ps
`default_nettype none
module rms_error_accumulator
    import rea_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // input beats: one sample pair each
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic signed [SAMPLE_W-1:0] s_sample_a,
    input  wire logic                       s_a_finite,
    input  wire logic signed [SAMPLE_W-1:0] s_sample_b,
    input  wire logic                       s_b_finite,
    input  wire logic                       s_last,
    // result beats: one per data set
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic             [MEAN_W-1:0]   m_mean_square,
    output logic             [ROOT_W-1:0]   m_rms,
    output logic             [CNT_W-1:0]    m_valid_count,
    output logic                            m_mismatch,
    output logic                            m_overflow
);

    // The controller owns the handshake on the input side and all step counting;
    // the datapath owns every data register and the output register.
    rea_cmd_t  cmd;
    rea_stat_t stat;

    rea_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_last),
        .s_ready (s_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    // Datapath: each square is registered, then added to the sum; on a last beat
    // the sum and count are snapshotted into the divider and the accumulator
    // clears, so the next data set starts from zero.
    rea_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_sample_a    (s_sample_a),
        .s_a_finite    (s_a_finite),
        .s_sample_b    (s_sample_b),
        .s_b_finite    (s_b_finite),
        .m_mean_square (m_mean_square),
        .m_rms         (m_rms),
        .m_valid_count (m_valid_count),
        .m_mismatch    (m_mismatch),
        .m_overflow    (m_overflow),
        .m_valid       (m_valid),
        .m_ready       (m_ready)
    );

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the RMS error accumulator: directed table, random sets.
`timescale 1ns / 1ps
module tb_top;
    import rea_pkg::*;

    // Expected result of one data set, field widths as on the m_ ports
    typedef struct packed {
        logic [MEAN_W-1:0] mean_sq;
        logic [ROOT_W-1:0] root;
        logic [CNT_W-1:0]  count;
        logic              mism;
        logic              ovf;
    } set_result_t;

    // One input beat plus, for directed rows, a result typed in by hand
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] a;
        logic                       a_fin;
        logic signed [SAMPLE_W-1:0] b;
        logic                       b_fin;
        logic                       lst;
        logic                       typed;
        set_result_t                res;
    } pair_row_t;

    localparam bit TYPED     = 1'b1;   // row carries its own expected result
    localparam bit PREDICTED = 1'b0;   // row is checked against the predictor
    localparam int N_DIRECTED = 19;
    localparam int RANDOM_BEATS = 380;
    localparam int MIN_RANDOM_SETS = 40;
    localparam int BACKLOG_CYCLES = 400;
    // one back-to-back set closes the run
    localparam int LAST_SET_BEATS = 30;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample_a = '0;
    logic                       s_a_finite = 1'b0;
    logic signed [SAMPLE_W-1:0] s_sample_b = '0;
    logic                       s_b_finite = 1'b0;
    logic                       s_last = 1'b0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [MEAN_W-1:0]          m_mean_square;
    logic [ROOT_W-1:0]          m_rms;
    logic [CNT_W-1:0]           m_valid_count;
    logic                       m_mismatch;
    logic                       m_overflow;

    // Side copy of the beat on the s_ ports, driven in step with them
    pair_row_t beat_note = '0;

    // Predictor state: running sum, count and sticky flags of the open set
    logic [SUM_W-1:0] acc_sum = '0;
    logic [CNT_W-1:0] acc_count = '0;
    logic             acc_mism = 1'b0;
    logic             acc_ovf = 1'b0;

    set_result_t set_results_due[$];
    int          fail_count = 0;
    int          sets_closed = 0;     // results taken off the m_ side
    bit          quiet = 1'b0;        // last part of the run: no idling anywhere
    bit          backlog_done = 1'b0;

    rms_error_accumulator DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample_a    (s_sample_a),
        .s_a_finite    (s_a_finite),
        .s_sample_b    (s_sample_b),
        .s_b_finite    (s_b_finite),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_mean_square (m_mean_square),
        .m_rms         (m_rms),
        .m_valid_count (m_valid_count),
        .m_mismatch    (m_mismatch),
        .m_overflow    (m_overflow)
    );

    always #5 aclk = ~aclk;

    // Floor square root, one result bit per pass from the top down
    function automatic logic [ROOT_W-1:0] floor_root(input logic [MEAN_W-1:0] x);
        logic [ROOT_W-1:0] r;
        logic [ROOT_W-1:0] trial;
        r = '0;
        for (int i = ROOT_W - 1; i >= 0; i--) begin
            trial = r | (ROOT_W'(1) << i);
            if (64'(trial) * 64'(trial) <= 64'(x)) r = trial;
        end
        return r;
    endfunction

    // Fold one accepted pair into the open set; on last, close the set and clear
    task automatic fold_pair(input logic signed [SAMPLE_W-1:0] a, input logic a_fin,
                             input logic signed [SAMPLE_W-1:0] b, input logic b_fin,
                             input logic lst, output logic closed, output set_result_t res);
        logic signed [SAMPLE_W:0] diff;
        logic [SAMPLE_W:0]        mag;
        logic [SUM_W-1:0]         quo;
        closed = 1'b0;
        res = '0;
        if (a_fin != b_fin) begin
            acc_mism = 1'b1;
        end else if (a_fin) begin
            // a finite pair at a full count is dropped but flags the overflow
            if (acc_count >= MAX_COUNT) begin
                acc_ovf = 1'b1;
            end else begin
                diff = (SAMPLE_W + 1)'(a) - (SAMPLE_W + 1)'(b);
                mag = diff[SAMPLE_W] ? -diff : diff;
                acc_sum = acc_sum + SUM_W'(SQ_W'(mag) * SQ_W'(mag));
                acc_count = acc_count + 1'b1;
            end
        end
        if (lst) begin
            // empty set gives zero mean and zero root
            quo = (acc_count == '0) ? '0 : acc_sum / SUM_W'(acc_count);
            res.mean_sq = quo[MEAN_W-1:0];
            res.root = floor_root(res.mean_sq);
            res.count = acc_count;
            res.mism = acc_mism;
            res.ovf = acc_ovf;
            closed = 1'b1;
            acc_sum = '0;
            acc_count = '0;
            acc_mism = 1'b0;
            acc_ovf = 1'b0;
        end
    endtask

    task automatic check_field(input string fname, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, fname, want, got);
        end
    endtask

    // Both handshakes are seen here, input first, at the same rising edge as the DUT
    always @(posedge aclk) begin : beat_monitor
        set_result_t want;
        logic        closed;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                fold_pair(s_sample_a, s_a_finite, s_sample_b, s_b_finite, s_last,
                          closed, want);
                // hand-typed rows take precedence; predictor state still advances
                if (closed) set_results_due.push_back(beat_note.typed ? beat_note.res : want);
            end
            if (m_valid && m_ready) begin
                sets_closed++;
                if (set_results_due.size() == 0) begin
                    fail_count++;
                    $display({"%0t: result with none expected: expected nothing, ",
                              "actual %0d %0d %0d %0d %0d"},
                             $time, m_mean_square, m_rms, m_valid_count, m_mismatch,
                             m_overflow);
                end else begin
                    want = set_results_due.pop_front();
                    check_field("mean_square", 64'(want.mean_sq), 64'(m_mean_square));
                    check_field("rms", 64'(want.root), 64'(m_rms));
                    check_field("valid_count", 64'(want.count), 64'(m_valid_count));
                    check_field("mismatch", 64'(want.mism), 64'(m_mismatch));
                    check_field("overflow", 64'(want.ovf), 64'(m_overflow));
                end
            end
        end
    end

    function automatic pair_row_t row(input logic [SAMPLE_W-1:0] a, input logic a_fin,
                                      input logic [SAMPLE_W-1:0] b, input logic b_fin,
                                      input logic lst, input logic typed,
                                      input logic [MEAN_W-1:0] mean_sq,
                                      input logic [ROOT_W-1:0] root,
                                      input logic [CNT_W-1:0] count,
                                      input logic mism, input logic ovf);
        pair_row_t r;
        r.a = a;
        r.a_fin = a_fin;
        r.b = b;
        r.b_fin = b_fin;
        r.lst = lst;
        r.typed = typed;
        r.res.mean_sq = mean_sq;
        r.res.root = root;
        r.res.count = count;
        r.res.mism = mism;
        r.res.ovf = ovf;
        return r;
    endfunction

    function automatic logic [SAMPLE_W-1:0] corner_sample();
        case ($urandom_range(0, 4))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'h0001;
        endcase
    endfunction

    // Random pair: mostly both finite, some one-sided, a few skipped
    function automatic pair_row_t random_pair(input logic lst);
        pair_row_t r;
        int        kind;
        r = '0;
        kind = $urandom_range(0, 99);
        r.a_fin = (kind >= 17) || (kind >= 5 && kind < 11);
        r.b_fin = (kind >= 11);
        case ($urandom_range(0, 3))
            0, 1: begin
                r.a = SAMPLE_W'($urandom);
                r.b = SAMPLE_W'($urandom);
            end
            2: begin
                // close values: small errors, the usual case for a fit
                r.a = SAMPLE_W'($urandom);
                r.b = r.a + SAMPLE_W'($urandom_range(0, 128)) - SAMPLE_W'(64);
            end
            default: begin
                r.a = corner_sample();
                r.b = corner_sample();
            end
        endcase
        r.lst = lst;
        return r;
    endfunction

    // Put a beat on the s_ ports and wait for it to be taken
    task automatic offer(input pair_row_t r);
        s_valid <= 1'b1;
        s_sample_a <= r.a;
        s_a_finite <= r.a_fin;
        s_sample_b <= r.b;
        s_b_finite <= r.b_fin;
        s_last <= r.lst;
        beat_note <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Gap after an accepted beat; none in the last part or in a no-idle stretch
    task automatic sender_gap(input bit idle_on);
        if (!quiet && idle_on && $urandom_range(0, 2) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    endtask

    initial begin : stimulus
        pair_row_t tbl [0:N_DIRECTED-1];
        pair_row_t r;
        bit        idle_on;
        int        set_len;
        int        random_beats;
        int        random_sets;

        //            a       a_f b       b_f last  check      mean          rms       cnt mm ov
        tbl[0]  = row(16'h0000, 0, 16'h0000, 0, 1, TYPED,     32'h0,        16'h0,    0, 0, 0);
        // largest difference both ways: square of 65535, exact root
        tbl[1]  = row(16'h7FFF, 1, 16'h8000, 1, 1, TYPED,     32'hFFFE0001, 16'hFFFF, 1, 0, 0);
        tbl[2]  = row(16'h8000, 1, 16'h7FFF, 1, 1, TYPED,     32'hFFFE0001, 16'hFFFF, 1, 0, 0);
        tbl[3]  = row(16'h8000, 1, 16'h8000, 1, 1, TYPED,     32'h0,        16'h0,    1, 0, 0);
        // one finite side only: flag set, nothing counted
        tbl[4]  = row(16'h7FFF, 1, 16'h0000, 0, 1, TYPED,     32'h0,        16'h0,    0, 1, 0);
        tbl[5]  = row(16'h0000, 0, 16'hFFFF, 1, 1, TYPED,     32'h0,        16'h0,    0, 1, 0);
        // sum 1 over count 2 truncates to zero
        tbl[6]  = row(16'h0001, 1, 16'h0000, 1, 0, PREDICTED, 32'h0,        16'h0,    0, 0, 0);
        tbl[7]  = row(16'h0000, 1, 16'h0000, 1, 1, TYPED,     32'h0,        16'h0,    2, 0, 0);
        // three max squares: sum past 32 bits, mean back at the top of range
        tbl[8]  = row(16'h7FFF, 1, 16'h8000, 1, 0, PREDICTED, 32'h0,        16'h0,    0, 0, 0);
        tbl[9]  = row(16'h8000, 1, 16'h7FFF, 1, 0, PREDICTED, 32'h0,        16'h0,    0, 0, 0);
        tbl[10] = row(16'h7FFF, 1, 16'h8000, 1, 1, TYPED,     32'hFFFE0001, 16'hFFFF, 3, 0, 0);
        // accumulation carries on past a one-sided pair and a skipped pair
        tbl[11] = row(16'h6400, 1, 16'hCE00, 1, 0, PREDICTED, 32'h0,        16'h0,    0, 0, 0);
        tbl[12] = row(16'h012C, 1, 16'h0000, 0, 0, PREDICTED, 32'h0,        16'h0,    0, 0, 0);
        tbl[13] = row(16'hFFFF, 0, 16'hFFFF, 0, 0, PREDICTED, 32'h0,        16'h0,    0, 0, 0);
        tbl[14] = row(16'hFF00, 1, 16'h0100, 1, 1, PREDICTED, 32'h0,        16'h0,    0, 0, 0);
        tbl[15] = row(16'h5555, 1, 16'hAAAA, 1, 0, PREDICTED, 32'h0,        16'h0,    0, 0, 0);
        tbl[16] = row(16'hAAAA, 1, 16'h5555, 1, 1, PREDICTED, 32'h0,        16'h0,    0, 0, 0);
        // neither side finite, extreme values: an empty set
        tbl[17] = row(16'h7FFF, 0, 16'h8000, 0, 1, TYPED,     32'h0,        16'h0,    0, 0, 0);
        tbl[18] = row(16'h0003, 1, 16'h0003, 1, 1, TYPED,     32'h0,        16'h0,    1, 0, 0);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        idle_on = 1'b1;
        for (int i = 0; i < N_DIRECTED; i++) begin
            offer(tbl[i]);
            sender_gap(idle_on);
        end

        // Random sets: mostly short, now and then a long one
        random_beats = 0;
        random_sets = 0;
        while (random_beats < RANDOM_BEATS || random_sets < MIN_RANDOM_SETS) begin
            set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(1, 12);
            for (int k = 0; k < set_len; k++) begin
                r = random_pair(k == set_len - 1);
                offer(r);
                if (r.a_fin || r.b_fin || r.lst) random_beats++;
                // switch between stretches with and without gaps
                if ($urandom_range(0, 39) == 0) idle_on = !idle_on;
                sender_gap(idle_on);
            end
            random_sets++;
        end

        // Last part: back-to-back beats, receiver always ready.
        quiet = 1'b1;
        for (int k = 0; k < LAST_SET_BEATS; k++) begin
            r = random_pair(k == LAST_SET_BEATS - 1);
            offer(r);
        end
        s_valid <= 1'b0;

        while (set_results_due.size() != 0) @(posedge aclk);
        // room for a stray late result: a bit over one divide and root
        repeat (100) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Result side: random ready bursts, one long hold-off to back the block up
    initial begin : result_sink
        while (!aresetn) @(posedge aclk);
        forever begin
            if (quiet) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else if (!backlog_done && sets_closed >= 14) begin
                // sender keeps going; the output register and then s_ready stall
                backlog_done = 1'b1;
                m_ready <= 1'b0;
                repeat (BACKLOG_CYCLES) @(posedge aclk);
            end else if ($urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    // Even with every beat closing a set under the longest stalls the run ends
    // before this watchdog fires
    initial begin : watchdog
        #(3_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
